/* design/eds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_pkg: shared constants for the 2-D euclidean distance pipeline
// Coordinate width default and the depth of the difference/square front end.
// ----------------------------------------------------------------------------
package eds_pkg;

  // default coordinate width (signed, fraction bits only name the scale)
  localparam int COORD_BITS_DEF = 24;

  // difference, magnitude, square and sum stages ahead of the root chain
  localparam int FRONT_STAGES = 4;

endpackage

/* design/euclidean_distance_2d.sv */
`timescale 1ns / 1ps
// Structure: four front stages, then one root cell per bit of the result.
// Throughput: one point pair per cycle unless in_stall is high; every stage is
//   its own register and a bubble anywhere in the chain lets a new pair in while
//   the result is stalled.
// Reset: synchronous, active low; clears all stage valid bits, payload is kept.
// ----------------------------------------------------------------------------
// euclidean_distance_2d: floor of the distance between two fixed-point points
// Differences, squares and their sum feed a chain of square root cells that
// produces the exact floor root in the coordinate scale.
// ----------------------------------------------------------------------------
module euclidean_distance_2d #(
  parameter int COORD_BITS = eds_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_first_x,
  input  logic signed [COORD_BITS-1:0] in_first_y,
  input  logic signed [COORD_BITS-1:0] in_second_x,
  input  logic signed [COORD_BITS-1:0] in_second_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [COORD_BITS:0]          out_distance
);
  import eds_pkg::*;

  localparam int RootBits = COORD_BITS + 1;
  localparam int RadBits  = 2 * RootBits;
  localparam int Stages   = FRONT_STAGES + RootBits;

  logic [Stages-1:0]       stage_valid;
  logic [Stages-1:0]       stage_en;
  logic [FRONT_STAGES-1:0] front_valid;
  logic [2*COORD_BITS:0]   sum;

  logic [RootBits-1:0]     cell_valid;
  logic [RadBits-1:0]      cell_rad  [RootBits];
  logic [RootBits:0]       cell_rem  [RootBits];
  logic [RootBits-1:0]     cell_root [RootBits];
  logic [RadBits-1:0]      first_rad;

  assign stage_valid = {cell_valid, front_valid};

  // a stage loads when some stage at or after it is empty or the result leaves
  for (genvar k = 0; k < Stages; k++) begin : g_en
    assign stage_en[k] = !out_stall || !(&stage_valid[Stages-1:k]);
  end

  assign in_stall = !stage_en[0];

  // front end: differences through sum of squares
  eds_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (stage_en[FRONT_STAGES-1:0]),
    .in_valid (in_valid),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .valid    (front_valid),
    .sum      (sum)
  );

  // radicand padded to an even number of bits
  assign first_rad = {{(RadBits - 2*COORD_BITS - 1){1'b0}}, sum};

  // root chain, most significant root bit first
  for (genvar i = 0; i < RootBits; i++) begin : g_cell
    if (i == 0) begin : g_head
      eds_cell #(
        .ROOT_BITS(RootBits)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (stage_en[FRONT_STAGES]),
        .in_valid  (front_valid[FRONT_STAGES-1]),
        .in_rad    (first_rad),
        .in_rem    ('0),
        .in_root   ('0),
        .out_valid (cell_valid[0]),
        .out_rad   (cell_rad[0]),
        .out_rem   (cell_rem[0]),
        .out_root  (cell_root[0])
      );
    end else begin : g_body
      eds_cell #(
        .ROOT_BITS(RootBits)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (stage_en[FRONT_STAGES+i]),
        .in_valid  (cell_valid[i-1]),
        .in_rad    (cell_rad[i-1]),
        .in_rem    (cell_rem[i-1]),
        .in_root   (cell_root[i-1]),
        .out_valid (cell_valid[i]),
        .out_rad   (cell_rad[i]),
        .out_rem   (cell_rem[i]),
        .out_root  (cell_root[i])
      );
    end
  end

  // last cell is the output register
  assign out_valid    = cell_valid[RootBits-1];
  assign out_distance = cell_root[RootBits-1];

  // input is held back only when every stage is full and the result is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&stage_valid) && out_stall))
    else $error("input stalled with a free stage in the pipeline");

  // a result taken with the stage behind it full is replaced next cycle
  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && stage_valid[Stages-2]) |=> out_valid)
    else $error("pipeline dropped a transaction at the output");

  // reset empties the chain
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && (stage_valid == '0)))
    else $error("valid bits survive reset");

endmodule

/* design/eds_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_front: difference, magnitude, square and sum stages
// Four registered stages that turn two points into dx*dx + dy*dy.
// ----------------------------------------------------------------------------
module eds_front #(
  parameter int COORD_BITS = eds_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic [eds_pkg::FRONT_STAGES-1:0]      en,
  input  logic                                  in_valid,
  input  logic signed [COORD_BITS-1:0]          first_x,
  input  logic signed [COORD_BITS-1:0]          first_y,
  input  logic signed [COORD_BITS-1:0]          second_x,
  input  logic signed [COORD_BITS-1:0]          second_y,
  output logic [eds_pkg::FRONT_STAGES-1:0]      valid,
  output logic [2*COORD_BITS:0]                 sum
);
  import eds_pkg::*;

  logic [FRONT_STAGES-1:0]      valid_r;
  logic [FRONT_STAGES-1:0]      valid_nxt;
  logic signed [COORD_BITS:0]   dx_diff_r, dy_diff_r;
  logic signed [COORD_BITS:0]   dx_diff_nxt, dy_diff_nxt;
  logic signed [COORD_BITS:0]   dx_neg, dy_neg;
  logic [COORD_BITS-1:0]        dx_mag_r, dy_mag_r;
  logic [COORD_BITS-1:0]        dx_mag_nxt, dy_mag_nxt;
  logic [2*COORD_BITS-1:0]      dx_sq_r, dy_sq_r;
  logic [2*COORD_BITS-1:0]      dx_sq_nxt, dy_sq_nxt;
  logic [2*COORD_BITS:0]        sum_r;
  logic [2*COORD_BITS:0]        sum_nxt;

  // valid bits move one stage forward whenever a stage loads
  always_comb begin
    for (int k = 0; k < FRONT_STAGES; k++) begin
      if (en[k]) begin
        valid_nxt[k] = (k == 0) ? in_valid : valid_r[(k == 0) ? 0 : k - 1];
      end else begin
        valid_nxt[k] = valid_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stage 0: signed differences, one bit wider than a coordinate
  assign dx_diff_nxt = {second_x[COORD_BITS-1], second_x} - {first_x[COORD_BITS-1], first_x};
  assign dy_diff_nxt = {second_y[COORD_BITS-1], second_y} - {first_y[COORD_BITS-1], first_y};

  // stage 1: magnitudes, which always fit a coordinate width unsigned
  assign dx_neg     = -dx_diff_r;
  assign dy_neg     = -dy_diff_r;
  assign dx_mag_nxt = dx_diff_r[COORD_BITS] ? dx_neg[COORD_BITS-1:0] : dx_diff_r[COORD_BITS-1:0];
  assign dy_mag_nxt = dy_diff_r[COORD_BITS] ? dy_neg[COORD_BITS-1:0] : dy_diff_r[COORD_BITS-1:0];

  // stage 2: one multiplier per axis
  assign dx_sq_nxt = dx_mag_r * dx_mag_r;
  assign dy_sq_nxt = dy_mag_r * dy_mag_r;

  // stage 3: exact sum of squares
  assign sum_nxt = {1'b0, dx_sq_r} + {1'b0, dy_sq_r};

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_diff_r <= dx_diff_nxt;
      dy_diff_r <= dy_diff_nxt;
    end
    if (en[1]) begin
      dx_mag_r <= dx_mag_nxt;
      dy_mag_r <= dy_mag_nxt;
    end
    if (en[2]) begin
      dx_sq_r <= dx_sq_nxt;
      dy_sq_r <= dy_sq_nxt;
    end
    if (en[3]) begin
      sum_r <= sum_nxt;
    end
  end

  assign valid = valid_r;
  assign sum   = sum_r;

endmodule

/* design/eds_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eds_cell: one digit of the restoring square root recurrence
// Takes two radicand bits, tries root*4+1 against the remainder, keeps one
// root bit and hands everything to the next cell.
// ----------------------------------------------------------------------------
module eds_cell #(
  parameter int ROOT_BITS = eds_pkg::COORD_BITS_DEF + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2*ROOT_BITS-1:0] in_rad,
  input  logic [ROOT_BITS:0]     in_rem,
  input  logic [ROOT_BITS-1:0]   in_root,
  output logic                   out_valid,
  output logic [2*ROOT_BITS-1:0] out_rad,
  output logic [ROOT_BITS:0]     out_rem,
  output logic [ROOT_BITS-1:0]   out_root
);
  import eds_pkg::*;

  localparam int RadBits = 2 * ROOT_BITS;

  logic                 valid_r;
  logic [RadBits-1:0]   rad_r, rad_nxt;
  logic [ROOT_BITS:0]   rem_r, rem_nxt;
  logic [ROOT_BITS-1:0] root_r, root_nxt;
  logic [ROOT_BITS+2:0] cur;
  logic [ROOT_BITS+2:0] trial;
  logic [ROOT_BITS+2:0] diff;
  logic                 take;

  // trial subtract of (root << 2) | 1 from the shifted remainder
  always_comb begin
    cur      = {in_rem, in_rad[RadBits-1:RadBits-2]};
    trial    = {1'b0, in_root, 2'b01};
    diff     = cur - trial;
    take     = (cur >= trial);
    rem_nxt  = take ? diff[ROOT_BITS:0] : cur[ROOT_BITS:0];
    root_nxt = {in_root[ROOT_BITS-2:0], take};
    rad_nxt  = {in_rad[RadBits-3:0], 2'b00};
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_rad   = rad_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;

endmodule
